>>> rtl/core/ppbd_pkg.sv
// Shared types, constants and helper functions of the bitplane-to-mono dither block.
// No dependencies; imported by every module of the block.
package ppbd_pkg;

    // APB register map, one 64-bit register every 8 bytes
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RESOLUTION = 3'd0,
        REG_PAL_0_3    = 3'd1,
        REG_PAL_4_7    = 3'd2,
        REG_PAL_8_11   = 3'd3,
        REG_PAL_12_15  = 3'd4
    } reg_idx_t;

    // Field widths
    localparam int PLANE_W   = 16;
    localparam int ROW_W     = 8;
    localparam int LUMA_W    = 4;
    localparam int COLOUR_W  = 12;
    localparam int PAL_REG_W = 48;
    localparam int OUT_ROW_W = 32;
    localparam int NUM_COLOURS = 16;
    localparam int IN_DATA_W  = 4 * PLANE_W + ROW_W;
    localparam int OUT_DATA_W = 2 * OUT_ROW_W;

    // Resolution codes
    localparam logic RES_LOW    = 1'b0;
    localparam logic RES_MEDIUM = 1'b1;

    // x*15/112 == (x*35115) >> 18 for the weighted sum x in 0..112
    localparam logic [15:0] LUMA_RECIP = 16'd35115;
    localparam int          LUMA_SHIFT = 18;

    // 4x4 Bayer matrix, row-major, index {row[1:0], col[1:0]}
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef logic [NUM_COLOURS-1:0][LUMA_W-1:0] luma_tab_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic      resolution;
        luma_tab_t luma_tab;
    } cfg_t;

    // Luminance 0..15 of one 3:3:3 palette colour
    function automatic logic [LUMA_W-1:0] colour_luma(input logic [COLOUR_W-1:0] c);
        logic [6:0]  wsum;
        logic [22:0] prod;
        wsum = 7'd5 * {4'd0, c[10:8]} + 7'd9 * {4'd0, c[6:4]} + 7'd2 * {4'd0, c[2:0]};
        prod = {16'd0, wsum} * {7'd0, LUMA_RECIP};
        return prod[LUMA_SHIFT +: LUMA_W];
    endfunction

    // Black when luma*32 < (2*bayer+1)*15
    function automatic logic is_black(input logic [LUMA_W-1:0] luma,
                                      input logic [1:0] row, input logic [1:0] col);
        logic [4:0] odd;
        logic [8:0] thresh;
        odd    = {BAYER[{row, col}], 1'b1};
        thresh = 9'd15 * {4'd0, odd};
        return {luma, 5'd0} < thresh;
    endfunction

endpackage

>>> rtl/core/ppbd_cfg.sv
// APB register bank: resolution and the four palette registers, plus the
// per-colour luma table derived from the palette. Depends on ppbd_pkg.
module ppbd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ppbd_pkg::cfg_t                 cfg
);
    import ppbd_pkg::*;

    logic                 resolution_reg;
    logic [PAL_REG_W-1:0] pal_reg [4];
    luma_tab_t            luma_tab_reg;
    luma_tab_t            luma_tab_next;
    reg_idx_t             idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_reg <= RES_LOW;
            pal_reg[0]     <= '0;
            pal_reg[1]     <= '0;
            pal_reg[2]     <= '0;
            pal_reg[3]     <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_RESOLUTION: resolution_reg <= pwdata[0];
                REG_PAL_0_3:    pal_reg[0] <= pwdata[PAL_REG_W-1:0];
                REG_PAL_4_7:    pal_reg[1] <= pwdata[PAL_REG_W-1:0];
                REG_PAL_8_11:   pal_reg[2] <= pwdata[PAL_REG_W-1:0];
                REG_PAL_12_15:  pal_reg[3] <= pwdata[PAL_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_RESOLUTION: prdata = {{(APB_DATA_W-1){1'b0}}, resolution_reg};
            REG_PAL_0_3:    prdata = {{(APB_DATA_W-PAL_REG_W){1'b0}}, pal_reg[0]};
            REG_PAL_4_7:    prdata = {{(APB_DATA_W-PAL_REG_W){1'b0}}, pal_reg[1]};
            REG_PAL_8_11:   prdata = {{(APB_DATA_W-PAL_REG_W){1'b0}}, pal_reg[2]};
            REG_PAL_12_15:  prdata = {{(APB_DATA_W-PAL_REG_W){1'b0}}, pal_reg[3]};
            default:        prdata = '0;
        endcase
    end

    // one luma unit per colour, result registered
    always_comb begin
        for (int c = 0; c < NUM_COLOURS; c++) begin
            luma_tab_next[c] = colour_luma(pal_reg[c / 4][(c % 4) * COLOUR_W +: COLOUR_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_tab_reg <= '0;
        end else begin
            luma_tab_reg <= luma_tab_next;
        end
    end

    assign cfg.resolution = resolution_reg;
    assign cfg.luma_tab   = luma_tab_reg;

endmodule

>>> rtl/core/ppbd_dither.sv
// Combinational dither of one 16-pixel group: index gather, luma lookup and
// Bayer threshold compare for both output rows. Depends on ppbd_pkg.
module ppbd_dither (
    input  logic [ppbd_pkg::PLANE_W-1:0]   plane0,
    input  logic [ppbd_pkg::PLANE_W-1:0]   plane1,
    input  logic [ppbd_pkg::PLANE_W-1:0]   plane2,
    input  logic [ppbd_pkg::PLANE_W-1:0]   plane3,
    input  logic                           row_lsb,
    input  ppbd_pkg::cfg_t                 cfg,
    output logic [ppbd_pkg::OUT_ROW_W-1:0] upper_bits,
    output logic [ppbd_pkg::OUT_ROW_W-1:0] lower_bits
);
    import ppbd_pkg::*;

    logic [3:0]        pix_idx [PLANE_W];
    logic [LUMA_W-1:0] pix_luma [PLANE_W];
    logic [1:0]        row_up;
    logic [1:0]        row_lo;

    assign row_up = {row_lsb, 1'b0};
    assign row_lo = {row_lsb, 1'b1};

    // colour index and luma of each source pixel, leftmost pixel first
    always_comb begin
        for (int p = 0; p < PLANE_W; p++) begin
            pix_idx[p] = {plane3[PLANE_W-1-p], plane2[PLANE_W-1-p],
                          plane1[PLANE_W-1-p], plane0[PLANE_W-1-p]};
            if (cfg.resolution == RES_MEDIUM) begin
                pix_idx[p][3:2] = 2'b00;
            end
            pix_luma[p] = cfg.luma_tab[pix_idx[p]];
        end
    end

    // threshold compare per output column
    always_comb begin
        upper_bits = '0;
        lower_bits = '0;
        if (cfg.resolution == RES_LOW) begin
            // each source pixel covers two output columns
            for (int x = 0; x < OUT_ROW_W; x++) begin
                upper_bits[OUT_ROW_W-1-x] = is_black(pix_luma[x / 2], row_up, 2'(x));
                lower_bits[OUT_ROW_W-1-x] = is_black(pix_luma[x / 2], row_lo, 2'(x));
            end
        end else begin
            for (int x = 0; x < PLANE_W; x++) begin
                upper_bits[PLANE_W-1-x] = is_black(pix_luma[x], row_up, 2'(x));
                lower_bits[PLANE_W-1-x] = is_black(pix_luma[x], row_lo, 2'(x));
            end
        end
    end

endmodule

>>> rtl/core/ppbd_pipe.sv
// Two-register stream pipeline: input word register, dither logic, result
// register, with per-stage valid and stall. Depends on ppbd_pkg, ppbd_dither.
module ppbd_pipe (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppbd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ppbd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  ppbd_pkg::cfg_t                  cfg
);
    import ppbd_pkg::*;

    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [IN_DATA_W-1:0]  in_word_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [OUT_DATA_W-1:0] out_word_reg;
    logic                  s_accept;
    logic                  advance;
    logic [OUT_ROW_W-1:0]  upper_bits;
    logic [OUT_ROW_W-1:0]  lower_bits;

    // stage handshake
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_reg <= s_tdata;
        end
        if (advance) begin
            out_word_reg <= {lower_bits, upper_bits};
        end
    end

    ppbd_dither u_dither (
        .plane0     (in_word_reg[0*PLANE_W +: PLANE_W]),
        .plane1     (in_word_reg[1*PLANE_W +: PLANE_W]),
        .plane2     (in_word_reg[2*PLANE_W +: PLANE_W]),
        .plane3     (in_word_reg[3*PLANE_W +: PLANE_W]),
        .row_lsb    (in_word_reg[4*PLANE_W]),
        .cfg        (cfg),
        .upper_bits (upper_bits),
        .lower_bits (lower_bits)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_word_reg;

endmodule

>>> rtl/core/planar_palette_bayer_dither_to_mono.sv
// Top level of the bitplane-to-mono Bayer dither block.
// Depends on ppbd_pkg, ppbd_cfg and ppbd_pipe.
//
// Takes one 16-pixel bitplane group per word and returns one word holding the
// two dithered monochrome output rows. A word is accepted every clock cycle
// while m_tready drains the result register; a word goes through the input
// register, then the result register, to m_tdata, and the input register
// takes one more word while a finished word waits. The per-colour luma table
// is recomputed from the palette registers into a register, so a palette
// write takes effect for words accepted from the cycle after the write.
module planar_palette_bayer_dither_to_mono (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // low to high: plane_zero_word[15:0], plane_one_word[31:16],
    // plane_two_word[47:32], plane_three_word[63:48], source_row[71:64]
    input  logic [ppbd_pkg::IN_DATA_W-1:0]  s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // low to high: upper_row_bits[31:0], lower_row_bits[63:32]
    output logic [ppbd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ppbd_pkg::*;

    cfg_t cfg;

    ppbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppbd_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg      (cfg)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the bitplane-to-mono Bayer dither block.
// Needs ppbd_pkg and planar_palette_bayer_dither_to_mono; a scoreboard checks every result word
// against known rows or a local dither predictor, first a directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
    import ppbd_pkg::*;

    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 188;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int TIMEOUT_NS    = 6_000_000;
    localparam int DIR_STEPS     = 25;

    // register numbers past the map, writes there must be dropped
    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // threshold ranks, row-major over (output row mod 4, output column mod 4)
    localparam int unsigned DITHER_RANK [16] = '{
        0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5
    };

    typedef enum logic {STEP_CFG, STEP_GROUP} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [2:0]  reg_sel;
        logic [63:0] wval;
        logic [7:0]  src_row;
        logic [15:0] pl3;
        logic [15:0] pl2;
        logic [15:0] pl1;
        logic [15:0] pl0;
        logic        known;
        logic [31:0] exp_lower;
        logic [31:0] exp_upper;
    } dir_step_t;

    // Directed table: known results where they follow directly from the palette
    localparam dir_step_t DIR_TAB [DIR_STEPS] = '{
        // after reset every colour is black
        '{STEP_GROUP, 3'd0, 64'h0, 8'd0, 16'hDEF0, 16'h9ABC, 16'h5678, 16'h1234,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd199, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        // colours 12..15 full white
        '{STEP_CFG, REG_PAL_12_15, 64'h0000_7777_7777_7777, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        // all ones on the bus: bits past 47 dropped, colour spare bits ignored
        '{STEP_CFG, REG_PAL_0_3, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b1, 32'h0, 32'h0},
        // only the ignored bits set: still black
        '{STEP_CFG, REG_PAL_0_3, 64'h0000_8888_8888_8888, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd2, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        // white on 4, pure primaries on 5..7
        '{STEP_CFG, REG_PAL_4_7, 64'h0000_7000_7000_7777, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd3, 16'h0000, 16'hFFFF, 16'hCCCC, 16'hF0F0,
          1'b0, 32'h0, 32'h0},
        '{STEP_CFG, REG_PAL_8_11, 64'h0000_7653_5612_4000, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd4, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h6666,
          1'b0, 32'h0, 32'h0},
        // writes past the register map change nothing
        '{STEP_CFG, REG_SPARE_5, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_CFG, REG_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'h0, 32'h0},
        // medium resolution: 16 bits per row, planes 2 and 3 ignored
        '{STEP_CFG, REG_RESOLUTION, 64'h1, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b1, 32'h0000_FFFF, 32'h0000_FFFF},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'h0000_FFFF, 32'h0000_FFFF},
        '{STEP_CFG, REG_PAL_0_3, 64'h0000_7770_7000_7000, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd0, 16'hABCD, 16'h1234, 16'hF0F0, 16'hFF00,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd1, 16'h0, 16'h0, 16'h3333, 16'h5555,
          1'b0, 32'h0, 32'h0},
        // only bit 0 of the resolution register counts
        '{STEP_CFG, REG_RESOLUTION, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd2, 16'h1008, 16'h2004, 16'h4002, 16'h8001,
          1'b0, 32'h0, 32'h0},
        '{STEP_GROUP, 3'd0, 64'h0, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 32'h0, 32'h0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the configuration registers
    logic        cfg_res;
    logic [47:0] cfg_pal [4];

    logic [OUT_DATA_W-1:0] rows_due [$];
    int  fail_count;
    int  rows_checked;
    int  groups_sent;
    int  cfg_writes;
    bit  src_gaps;
    bit  sink_gaps;
    bit  long_hold_req;

    planar_palette_bayer_dither_to_mono u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void log_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // Expected pair of dithered rows for one plane group under the shadow config
    function automatic logic [OUT_DATA_W-1:0] dither_group(input logic [IN_DATA_W-1:0] w);
        int unsigned lum [16];
        int unsigned idx;
        int unsigned clr;
        int unsigned rank;
        int unsigned nbits;
        logic [31:0] rows [2];
        for (int p = 0; p < 16; p++) begin
            idx = {w[63-p], w[47-p], w[31-p], w[15-p]};
            if (cfg_res == RES_MEDIUM) begin
                idx = idx & 3;
            end
            clr = 32'((cfg_pal[idx >> 2] >> ((idx & 3) * 12)) & 48'hFFF);
            lum[p] = (((clr >> 8) & 7) * 5 + ((clr >> 4) & 7) * 9 + (clr & 7) * 2) * 15 / 112;
        end
        nbits = (cfg_res == RES_LOW) ? 32 : 16;
        for (int k = 0; k < 2; k++) begin
            rows[k] = '0;
            for (int x = 0; x < nbits; x++) begin
                rank = DITHER_RANK[(((w[64] * 2) + k) & 3) * 4 + (x & 3)];
                // low resolution doubles each source pixel
                if (lum[(cfg_res == RES_LOW) ? (x >> 1) : x] * 32 < (2 * rank + 1) * 15) begin
                    rows[k][nbits - 1 - x] = 1'b1;
                end
            end
        end
        return {rows[1], rows[0]};
    endfunction

    // APB write: setup then access, then the bus returns to idle; shadow updated as the block would
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RESOLUTION) begin
            cfg_res = val[0];
        end else if (idx <= REG_PAL_12_15) begin
            cfg_pal[idx - 1] = val[47:0];
        end
        cfg_writes++;
        @(posedge aclk);
    endtask

    // Wait for every result word, then let the pipeline empty
    task automatic settle();
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Offer one group word, record its expected rows on acceptance
    task automatic send_group(input logic [IN_DATA_W-1:0] word, input bit known,
                              input logic [OUT_DATA_W-1:0] known_rows);
        int gap;
        gap = src_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
        rows_due.push_back(known ? known_rows : dither_group(word));
        groups_sent++;
    endtask

    // Result side backpressure, with an occasional long hold
    initial begin
        int stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = sink_gaps ? $urandom_range(0, 19) : 0;
            if (long_hold_req) begin
                stall = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Scoreboard: each result word against the oldest expectation
    always @(posedge aclk) begin
        logic [OUT_DATA_W-1:0] want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (rows_due.size() == 0) begin
                log_fail($sformatf("unexpected word %h", m_tdata));
            end else begin
                want = rows_due.pop_front();
                rows_checked++;
                if (m_tdata[31:0] !== want[31:0]) begin
                    log_fail($sformatf("upper row exp %h act %h", want[31:0], m_tdata[31:0]));
                end
                if (m_tdata[63:32] !== want[63:32]) begin
                    log_fail($sformatf("lower row exp %h act %h", want[63:32], m_tdata[63:32]));
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d words outstanding", rows_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [15:0]          pl [4];
        logic [3:0]           flat_idx;
        logic [47:0]          pal_val;
        logic [IN_DATA_W-1:0] word;
        dir_step_t            st;

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        cfg_res  = RES_LOW;
        for (int i = 0; i < 4; i++) begin
            cfg_pal[i] = '0;
        end
        fail_count    = 0;
        rows_checked  = 0;
        groups_sent   = 0;
        cfg_writes    = 0;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        long_hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed table
        for (int i = 0; i < DIR_STEPS; i++) begin
            st = DIR_TAB[i];
            if (st.kind == STEP_CFG) begin
                s_tvalid <= 1'b0;
                settle();
                reg_write(st.reg_sel, st.wval);
                @(posedge aclk);
            end else begin
                send_group({st.src_row, st.pl3, st.pl2, st.pl1, st.pl0}, st.known,
                           {st.exp_lower, st.exp_upper});
            end
        end
        s_tvalid <= 1'b0;

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            src_gaps  = (ph % 3 != 2) && (ph != 4);
            sink_gaps = (ph % 4 != 3);
            reg_write(REG_RESOLUTION, {$urandom, $urandom} & ~64'h1 | 64'(ph & 1));
            for (int r = 0; r < 4; r++) begin
                if (ph == 2) begin
                    pal_val = '0;
                end else if (ph == 3) begin
                    pal_val = '1;
                end else begin
                    pal_val = {12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)};
                end
                reg_write(3'(r + 1), {16'($urandom), pal_val});
            end
            @(posedge aclk);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // stall the result side while words keep coming
                if (ph == 4 && n == 40) begin
                    long_hold_req = 1'b1;
                end
                // sender pause until everything is back
                if (ph == 6 && n == PHASE_WORDS / 2) begin
                    s_tvalid <= 1'b0;
                    do @(posedge aclk); while (rows_due.size() != 0);
                end
                if ($urandom_range(0, 3) == 0) begin
                    // flat run of one colour index
                    flat_idx = 4'($urandom);
                    for (int b = 0; b < 4; b++) begin
                        pl[b] = {16{flat_idx[b]}};
                    end
                end else begin
                    for (int b = 0; b < 4; b++) begin
                        pl[b] = 16'($urandom);
                    end
                end
                word = {8'($urandom_range(0, 255)), pl[3], pl[2], pl[1], pl[0]};
                send_group(word, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        // final drain with a bound
        for (int i = 0; i < 5000 && rows_due.size() != 0; i++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (rows_due.size() != 0) begin
            log_fail($sformatf("%0d expected words never arrived", rows_due.size()));
        end

        $display("Run: %0d plane groups, %0d register writes, both resolutions, %0d phases.",
                 groups_sent, cfg_writes, PHASES);
        $display("Checked %0d result words, %0d failures.", rows_checked, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
